>>> rtl/tgarle_pkg.sv
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants for the TGA run-length scanline decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RLE_ENABLE   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LINE_WIDTH   = 2'd2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0] AlphaOpaque = 8'd255;
  localparam logic [7:0] CountMask   = 8'd127;

  // Pixel format codes; the unused code decodes as BGRA
  typedef enum logic [1:0] {
    FMT_GRAY = 2'd0,
    FMT_BGR  = 2'd1,
    FMT_BGRA = 2'd2
  } fmt_e;

  typedef struct packed {
    logic [1:0]  pixel_format;
    logic        rle_enable;
    logic [15:0] line_width;
  } cfg_t;

  // Decoder stream state; line_pos stays below the effective line width
  typedef struct packed {
    logic        expect_header;
    logic [1:0]  byte_slot;
    logic [23:0] pixel_bytes;
    logic [7:0]  packet_left;
    logic        packet_is_run;
    logic [7:0]  run_length;
    logic [15:0] line_pos;
  } state_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_res;
    logic [15:0] column;
    logic        line_end;
  } result_t;

  localparam state_t StateRestart = '{
    expect_header: 1'b1,
    byte_slot:     2'd0,
    pixel_bytes:   24'd0,
    packet_left:   8'd0,
    packet_is_run: 1'b0,
    run_length:    8'd0,
    line_pos:      16'd0
  };

endpackage

>>> rtl/tgarle_if.sv
// ----------------------------------------------------------------------------
// tgarle channel interfaces
// Valid/ready channels for the byte stream and the decoded pixel words.
// ----------------------------------------------------------------------------
interface tgarle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tgarle_pix_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [7:0]  repeat_res;
  logic [15:0] column;
  logic        line_end;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output repeat_res, output column, output line_end, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input repeat_res, input column, input line_end, output ready);
endinterface

>>> rtl/tgarle_decode.sv
// ----------------------------------------------------------------------------
// tgarle_decode
// Next-state and result logic for one byte of the image data stream.
// ----------------------------------------------------------------------------
module tgarle_decode
  import tgarle_pkg::*;
(
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  logic [7:0] byte_i,
  output state_t  state_o,
  output logic    res_valid_o,
  output result_t res_o
);

  logic [15:0] width;
  logic [2:0]  nbytes;
  logic [15:0] room;
  logic [7:0]  rep;
  logic [16:0] pos_sum;
  logic        line_done;
  logic [7:0]  count;
  logic [7:0]  left_dec;

  // Effective width and bytes per pixel
  always_comb begin
    width = (cfg_i.line_width == 16'd0) ? 16'd1 : cfg_i.line_width;
    case (fmt_e'(cfg_i.pixel_format))
      FMT_GRAY: nbytes = 3'd1;
      FMT_BGR:  nbytes = 3'd3;
      default:  nbytes = 3'd4;
    endcase
  end

  // Run length clipped to the room left on the line
  always_comb begin
    room = width - state_i.line_pos;
    if (state_i.packet_is_run && cfg_i.rle_enable) begin
      rep = ({8'd0, state_i.run_length} < room) ? state_i.run_length : room[7:0];
      if (rep == 8'd0) begin
        rep = 8'd1;
      end
    end else begin
      rep = 8'd1;
    end
    pos_sum   = {1'b0, state_i.line_pos} + {9'd0, rep};
    line_done = (pos_sum >= {1'b0, width});
    count     = (byte_i & CountMask) + 8'd1;
    left_dec  = state_i.packet_left - 8'd1;
  end

  // State update and result word
  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (cfg_i.rle_enable && state_i.expect_header) begin
      // packet header
      state_o.packet_is_run = byte_i[7];
      if (byte_i[7]) begin
        state_o.run_length = count;
      end else begin
        state_o.packet_left = count;
      end
      state_o.expect_header = 1'b0;
      state_o.byte_slot     = 2'd0;
    end else if (({1'b0, state_i.byte_slot} + 3'd1) < nbytes) begin
      // collect a leading pixel byte
      case (state_i.byte_slot)
        2'd0:    state_o.pixel_bytes[7:0]   = byte_i;
        2'd1:    state_o.pixel_bytes[15:8]  = byte_i;
        default: state_o.pixel_bytes[23:16] = byte_i;
      endcase
      state_o.byte_slot = state_i.byte_slot + 2'd1;
    end else begin
      // last byte of the pixel: emit a word
      res_valid_o = 1'b1;
      case (nbytes)
        3'd1: begin
          res_o.red   = byte_i;
          res_o.green = byte_i;
          res_o.blue  = byte_i;
          res_o.alpha = AlphaOpaque;
        end
        3'd3: begin
          res_o.blue  = state_i.pixel_bytes[7:0];
          res_o.green = state_i.pixel_bytes[15:8];
          res_o.red   = byte_i;
          res_o.alpha = AlphaOpaque;
        end
        default: begin
          res_o.blue  = state_i.pixel_bytes[7:0];
          res_o.green = state_i.pixel_bytes[15:8];
          res_o.red   = state_i.pixel_bytes[23:16];
          res_o.alpha = byte_i;
        end
      endcase
      res_o.repeat_res = rep;
      res_o.column     = state_i.line_pos;
      res_o.line_end   = line_done;
      state_o.byte_slot = 2'd0;
      state_o.line_pos  = line_done ? 16'd0 : pos_sum[15:0];
      if (cfg_i.rle_enable) begin
        if (state_i.packet_is_run) begin
          state_o.expect_header = 1'b1;
        end else begin
          state_o.packet_left = left_dec;
          if (left_dec == 8'd0 || line_done) begin
            state_o.expect_header = 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> rtl/tga_rle_scanline_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_scanline_decoder
// Decodes TGA image data bytes into pixel words, one scanline at a time.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on in_if while no held word stalls and produces
// at most one pixel word per byte on out_if: a word for every pixel's last
// byte, carrying a repeat count for run packets (clipped to the line end),
// its start column and a line-end flag. Header bytes and leading pixel bytes
// give no word. Each byte is decoded in the cycle it is accepted; the word
// sits in an output register, and a new byte is taken in the same cycle the
// held word is taken, so the sustained rate is one byte per clock. A write
// to any of the three registers restarts decoding at column 0, awaiting a
// packet header in coded mode; write only while no word is pending.
module tga_rle_scanline_decoder
  import tgarle_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  tgarle_byte_if.sink         in_if,
  tgarle_pix_if.source        out_if
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t res_d, out_q;
  logic    res_valid;
  logic    out_valid_q;
  logic    in_accept;
  logic    cfg_hit;

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_accept   = in_if.valid && in_if.ready;
  assign cfg_hit     = cfg_we_i && (cfg_index_i == REG_PIXEL_FORMAT ||
                                    cfg_index_i == REG_RLE_ENABLE ||
                                    cfg_index_i == REG_LINE_WIDTH);

  tgarle_decode u_decode (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .byte_i      (in_if.in_byte),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res_d)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format <= FMT_BGR;
      cfg_q.rle_enable   <= 1'b0;
      cfg_q.line_width   <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_data_i[1:0];
        REG_RLE_ENABLE:   cfg_q.rle_enable   <= cfg_data_i[0];
        REG_LINE_WIDTH:   cfg_q.line_width   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRestart;
    end else if (cfg_hit) begin
      state_q <= StateRestart;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      out_valid_q <= in_accept && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && res_valid) begin
      out_q <= res_d;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.red        = out_q.red;
  assign out_if.green      = out_q.green;
  assign out_if.blue       = out_q.blue;
  assign out_if.alpha      = out_q.alpha;
  assign out_if.repeat_res = out_q.repeat_res;
  assign out_if.column     = out_q.column;
  assign out_if.line_end   = out_q.line_end;

  // Position never reaches the line width
  a_pos_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_q.line_width == 16'd0) ? (state_q.line_pos == 16'd0)
                                : (state_q.line_pos < cfg_q.line_width))
    else $error("line position past line width");

  // Partial pixel slot stays below the pixel size
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_q.pixel_format == FMT_GRAY) ? (state_q.byte_slot == 2'd0) :
    (cfg_q.pixel_format == FMT_BGR)  ? (state_q.byte_slot != 2'd3) : 1'b1)
    else $error("byte slot out of range");

  // Words carry a repeat count of 1 to 128
  a_repeat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.repeat_res != 8'd0 && out_q.repeat_res <= 8'd128))
    else $error("repeat count out of range");

  // Header bytes never produce a word
  a_header_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && cfg_q.rle_enable && state_q.expect_header && !cfg_we_i)
      |=> !out_valid_q)
    else $error("word produced from header byte");

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the TGA run-length scanline decoder. A short table
// of directed bytes and register writes covers the pixel formats, run and raw
// packets, line clipping and the odd register values, then random phases of
// packet-shaped byte streams under random settings. Each pixel word is
// checked against its typed table entry or a cycle-free decoder model here.
// ----------------------------------------------------------------------------
module testbench;
  import tgarle_pkg::*;

  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned ByteBudget = 500;

  // Codes with no name in the package
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
  localparam logic [1:0]         FMT_SPARE  = 2'd3;

  localparam cfg_t RegsReset = '{pixel_format: FMT_BGR, rle_enable: 1'b0, line_width: 16'd1};

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    bit                   pinned;
    result_t              want;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  tgarle_byte_if in_if ();
  tgarle_pix_if  out_if ();

  tga_rle_scanline_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  // Decoder model: registers and stream state
  cfg_t    regs;
  state_t  stream;
  result_t pending_pix[$];

  // Expectation typed into the directed table, travels with its byte
  logic    pinned_chk;
  result_t pinned_pix;

  result_t seen_pix;
  result_t want_pix;
  int      bad_words;
  int      quiet;
  int      bytes_sent;
  bit      sender_gaps;
  bit      receiver_gaps;
  bit      hold_req;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Decode one accepted byte; returns 1 when it completes a pixel word
  function automatic bit decode_byte(input logic [7:0] b, output result_t px);
    int unsigned width;
    int unsigned nbytes;
    int unsigned room;
    int unsigned rep;
    int unsigned pos;
    logic        fin;
    px = '0;
    width = (regs.line_width == 16'd0) ? 1 : regs.line_width;
    if (regs.rle_enable && stream.expect_header) begin
      stream.packet_is_run = b[7];
      if (b[7]) begin
        stream.run_length = {1'b0, b[6:0]} + 8'd1;
      end else begin
        stream.packet_left = {1'b0, b[6:0]} + 8'd1;
      end
      stream.expect_header = 1'b0;
      stream.byte_slot = 2'd0;
      return 1'b0;
    end
    nbytes = (regs.pixel_format == FMT_GRAY) ? 1 : (regs.pixel_format == FMT_BGR) ? 3 : 4;
    if (stream.byte_slot + 1 < nbytes) begin
      stream.pixel_bytes[8*stream.byte_slot +: 8] = b;
      stream.byte_slot = stream.byte_slot + 2'd1;
      return 1'b0;
    end
    // last byte of the pixel: assemble the color
    if (nbytes == 1) begin
      px.red = b;
      px.green = b;
      px.blue = b;
      px.alpha = AlphaOpaque;
    end else begin
      px.blue = stream.pixel_bytes[7:0];
      px.green = stream.pixel_bytes[15:8];
      px.red = (nbytes == 3) ? b : stream.pixel_bytes[23:16];
      px.alpha = (nbytes == 3) ? AlphaOpaque : b;
    end
    stream.byte_slot = 2'd0;
    // runs are clipped to the line end
    rep = 1;
    if (regs.rle_enable && stream.packet_is_run) begin
      room = (stream.line_pos < width) ? width - stream.line_pos : 1;
      rep = (stream.run_length < room) ? stream.run_length : room;
      if (rep == 0) rep = 1;
    end
    pos = stream.line_pos + rep;
    fin = (pos >= width);
    px.column = stream.line_pos;
    px.repeat_res = rep[7:0];
    px.line_end = fin;
    stream.line_pos = fin ? 16'd0 : pos[15:0];
    if (regs.rle_enable) begin
      if (stream.packet_is_run) begin
        stream.expect_header = 1'b1;
      end else begin
        stream.packet_left = stream.packet_left - 8'd1;
        if (stream.packet_left == 8'd0 || fin) stream.expect_header = 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic string show(input result_t px);
    return $sformatf("r=%02h g=%02h b=%02h a=%02h rep=%0d col=%0d end=%0b",
                     px.red, px.green, px.blue, px.alpha, px.repeat_res, px.column,
                     px.line_end);
  endfunction

  task automatic report(input string what, input result_t want, input result_t seen);
    bad_words++;
    if (bad_words <= 10) begin
      $display("%0t: %s: expected %s, got %s", $realtime, what, show(want), show(seen));
    end
  endtask

  // Monitor: follows register writes, predicts accepted bytes, checks words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = RegsReset;
      stream = StateRestart;
      pending_pix.delete();
      quiet = 0;
    end else begin
      quiet++;
      if (out_if.valid && out_if.ready) begin
        quiet = 0;
        seen_pix = '{red: out_if.red, green: out_if.green, blue: out_if.blue,
                     alpha: out_if.alpha, repeat_res: out_if.repeat_res,
                     column: out_if.column, line_end: out_if.line_end};
        if (pending_pix.size() == 0) begin
          report("word with none pending", '0, seen_pix);
        end else begin
          want_pix = pending_pix.pop_front();
          if (seen_pix !== want_pix) report("pixel word mismatch", want_pix, seen_pix);
        end
      end
      if (cfg_we_i) begin
        quiet = 0;
        case (cfg_index_i)
          REG_PIXEL_FORMAT: begin
            regs.pixel_format = cfg_data_i[1:0];
            stream = StateRestart;
          end
          REG_RLE_ENABLE: begin
            regs.rle_enable = cfg_data_i[0];
            stream = StateRestart;
          end
          REG_LINE_WIDTH: begin
            regs.line_width = cfg_data_i;
            stream = StateRestart;
          end
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        quiet = 0;
        if (decode_byte(in_if.in_byte, want_pix) || pinned_chk) begin
          pending_pix.push_back(pinned_chk ? pinned_pix : want_pix);
        end
      end
      if (quiet >= QuietLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Pixel sink: random stall bursts, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one byte, maybe after a gap, and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input bit chk, input result_t want);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    pinned_chk <= chk;
    pinned_pix <= want;
    bytes_sent++;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Stop sending until every pending word is out and the block is quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    pinned_chk <= 1'b0;
    do @(posedge clk_i); while (pending_pix.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                   input logic [CfgDataW-1:0] val);
    return '{kind: ROW_CFG, idx: idx, data: val, pinned: 1'b0, want: '0};
  endfunction

  function automatic row_t byte_row(input logic [7:0] b);
    return '{kind: ROW_BYTE, idx: '0, data: {8'd0, b}, pinned: 1'b0, want: '0};
  endfunction

  function automatic row_t pix_row(input logic [7:0] b, r, g, bl, a, rep,
                                   input logic [15:0] col, input logic fin);
    return '{kind: ROW_BYTE, idx: '0, data: {8'd0, b}, pinned: 1'b1,
             want: '{red: r, green: g, blue: bl, alpha: a, repeat_res: rep,
                     column: col, line_end: fin}};
  endfunction

  // Stimulus
  initial begin
    row_t        directed[$];
    int unsigned phase;
    int unsigned width;
    int unsigned w_eff;
    int unsigned nb;
    int unsigned col;
    int unsigned cnt;
    int unsigned pixels;
    int unsigned n_bytes;
    int unsigned start;
    logic [1:0]  fmt;
    logic        rle;
    logic [7:0]  hdr;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'd0;
    pinned_chk = 1'b0;
    pinned_pix = '0;
    bad_words = 0;
    bytes_sent = 0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    hold_req = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      // reset settings: BGR, uncoded, one pixel per line
      byte_row(8'h00), byte_row(8'hFF),
      pix_row(8'h80, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'd1, 16'd0, 1'b1),
      // gray with zero width acts as width one
      cfg_row(REG_PIXEL_FORMAT, {14'd0, FMT_GRAY}), cfg_row(REG_LINE_WIDTH, 16'd0),
      pix_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd1, 16'd0, 1'b1),
      pix_row(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'd1, 16'd0, 1'b1),
      // write to the spare index changes nothing
      cfg_row(REG_UNUSED, 16'hFFFF),
      pix_row(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'hFF, 8'd1, 16'd0, 1'b1),
      // spare format code decodes as BGRA; runs clipped at the line end
      cfg_row(REG_PIXEL_FORMAT, {14'd0, FMT_SPARE}), cfg_row(REG_LINE_WIDTH, 16'd4),
      cfg_row(REG_RLE_ENABLE, 16'd1),
      byte_row(8'h81), byte_row(8'h01), byte_row(8'h02), byte_row(8'h03),
      pix_row(8'h04, 8'h03, 8'h02, 8'h01, 8'h04, 8'd2, 16'd0, 1'b0),
      byte_row(8'hFF), byte_row(8'h10), byte_row(8'h20), byte_row(8'h30),
      pix_row(8'h40, 8'h30, 8'h20, 8'h10, 8'h40, 8'd2, 16'd2, 1'b1),
      // raw packet longer than the line: the rest is dropped
      cfg_row(REG_PIXEL_FORMAT, {14'd0, FMT_GRAY}), cfg_row(REG_LINE_WIDTH, 16'd3),
      byte_row(8'h04), byte_row(8'h11), byte_row(8'h22), byte_row(8'h33),
      byte_row(8'h00), byte_row(8'h44),
      // widest line, longest run
      cfg_row(REG_LINE_WIDTH, 16'hFFFF),
      byte_row(8'hFF),
      pix_row(8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hFF, 8'd128, 16'd0, 1'b0)
    };

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_byte(directed[i].data[7:0], directed[i].pinned, directed[i].want);
      end
    end

    // Random phases, each under fresh settings
    phase = 0;
    while (bytes_sent < ByteBudget) begin
      if (bytes_sent >= ByteBudget - 80) begin
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
      end
      fmt = 2'($urandom_range(0, 3));
      rle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: width = 0;
        1: width = 16'hFFFF;
        2: width = $urandom_range(0, 16'hFFFF);
        3: width = 1;
        default: width = $urandom_range(2, 12);
      endcase
      settle();
      write_reg(REG_PIXEL_FORMAT, {14'd0, fmt});
      write_reg(REG_RLE_ENABLE, {15'd0, rle});
      write_reg(REG_LINE_WIDTH, width[15:0]);
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom_range(0, 16'hFFFF)));
      // sink holds off while bytes keep coming
      if (phase == 1) hold_req = 1'b1;

      w_eff = (width == 0) ? 1 : width;
      nb = (fmt == FMT_GRAY) ? 1 : (fmt == FMT_BGR) ? 3 : 4;
      col = 0;
      n_bytes = $urandom_range(30, 60);
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
        if (!rle || $urandom_range(0, 9) == 0) begin
          // uncoded data, or a stray byte that breaks packet framing
          send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
          hdr[7] = 1'($urandom_range(0, 1));
          hdr[6:0] = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(0, 7));
          cnt = hdr[6:0] + 1;
          send_byte(hdr, 1'b0, '0);
          if (hdr[7]) begin
            pixels = 1;
            col = col + ((cnt < w_eff - col) ? cnt : w_eff - col);
          end else begin
            pixels = (cnt < w_eff - col) ? cnt : w_eff - col;
            col = col + pixels;
          end
          if (col >= w_eff) col = 0;
          repeat (pixels * nb) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end
      end
      phase++;
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (bad_words == 0 && pending_pix.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
